FILE: design/assert_macros.svh
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Checks that a condition never holds at a rising clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`endif

FILE: design/scd_pkg.sv
`default_nettype none

package scd_pkg;

    // Field widths.
    localparam int CODE_W = 8;
    localparam int CHAR_W = 7;

    // Character FIFO geometry.
    localparam int FIFO_DEPTH = 32;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);

    // Operation queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Translation table geometry.
    localparam int TABLE_SIZE = 59;
    localparam int IDX_W      = $clog2(TABLE_SIZE);

    // Scan codes with a special meaning.
    localparam logic [CODE_W-1:0] SC_LSHIFT_MAKE  = 8'h2A;
    localparam logic [CODE_W-1:0] SC_RSHIFT_MAKE  = 8'h36;
    localparam logic [CODE_W-1:0] SC_LSHIFT_BREAK = 8'hAA;
    localparam logic [CODE_W-1:0] SC_RSHIFT_BREAK = 8'hB6;
    localparam logic [CODE_W-1:0] SC_BREAK_MASK   = 8'h80;

    // Command codes of an input transaction.
    localparam logic CMD_SCANCODE = 1'b0;
    localparam logic CMD_READ     = 1'b1;

    // Unshifted translation table.
    localparam logic [CHAR_W-1:0] PLAIN_MAP [TABLE_SIZE] = '{
        7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
        7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
        7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
        7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
        7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
        7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20, 7'h00
    };

    // Shifted translation table.
    localparam logic [CHAR_W-1:0] SHIFTED_MAP [TABLE_SIZE] = '{
        7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
        7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
        7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
        7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
        7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
        7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20, 7'h00
    };

    // One operation for the back end: a read, or a push of a character.
    typedef struct packed {
        logic              is_read;
        logic [CHAR_W-1:0] ch;
    } t_op;

    // An operation together with its valid flag.
    typedef struct packed {
        logic valid;
        t_op  op;
    } t_op_req;

    // Translates a make code; codes beyond the table give no character.
    function automatic logic [CHAR_W-1:0] map_char(input logic shift,
                                                   input logic [CODE_W-1:0] code);
        logic [CHAR_W-1:0] ch;
        ch = '0;
        if (code < CODE_W'(TABLE_SIZE)) begin
            ch = shift ? SHIFTED_MAP[code[IDX_W-1:0]] : PLAIN_MAP[code[IDX_W-1:0]];
        end
        return ch;
    endfunction

endpackage

`default_nettype wire

FILE: design/scd_front.sv
`default_nettype none

module scd_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    input  wire logic                        i_command,
    input  wire logic [scd_pkg::CODE_W-1:0]  i_scancode,
    input  wire logic                        i_aux_data,
    input  wire logic                        i_queue_full,
    output logic                             o_stall,
    output scd_pkg::t_op_req                 o_req
);

    logic r_shift_held;
    logic n_shift_held;
    logic accept;

    // A transaction is taken whenever the operation queue has room.
    assign o_stall = i_queue_full;
    assign accept  = i_valid && !i_queue_full;

    // Classify the transaction: shift tracking, lookup, or a read.
    always_comb begin
        n_shift_held    = r_shift_held;
        o_req.valid     = 1'b0;
        o_req.op.is_read = 1'b0;
        o_req.op.ch     = '0;
        if (accept) begin
            if (i_command == scd_pkg::CMD_READ) begin
                o_req.valid      = 1'b1;
                o_req.op.is_read = 1'b1;
            end else if (!i_aux_data) begin
                if (i_scancode inside {scd_pkg::SC_LSHIFT_MAKE, scd_pkg::SC_RSHIFT_MAKE}) begin
                    n_shift_held = 1'b1;
                end else if (i_scancode inside {scd_pkg::SC_LSHIFT_BREAK,
                                                scd_pkg::SC_RSHIFT_BREAK}) begin
                    n_shift_held = 1'b0;
                end else if ((i_scancode & scd_pkg::SC_BREAK_MASK) == '0) begin
                    o_req.op.ch = scd_pkg::map_char(r_shift_held, i_scancode);
                    o_req.valid = (o_req.op.ch != '0);
                end
            end
        end
    end

    // Shift state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift_held <= 1'b0;
        end else begin
            r_shift_held <= n_shift_held;
        end
    end

endmodule

`default_nettype wire

FILE: design/scd_queue.sv
`default_nettype none

module scd_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire scd_pkg::t_op_req i_push,
    input  wire logic             i_pop,
    output logic                  o_full,
    output scd_pkg::t_op_req      o_head
);

    scd_pkg::t_op                     r_slot [scd_pkg::QUEUE_DEPTH];
    logic [scd_pkg::QIDX_W-1:0]       r_wr_idx;
    logic [scd_pkg::QIDX_W-1:0]       r_rd_idx;
    logic [scd_pkg::QCNT_W-1:0]       r_count;
    logic                             do_pop;

    assign o_full       = (r_count == scd_pkg::QCNT_W'(scd_pkg::QUEUE_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.op    = r_slot[r_rd_idx];
    assign do_pop       = i_pop && o_head.valid;

    // Slot storage.
    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_slot[r_wr_idx] <= i_push.op;
        end
    end

    // Indices and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx <= '0;
            r_rd_idx <= '0;
            r_count  <= '0;
        end else begin
            if (i_push.valid) begin
                r_wr_idx <= (r_wr_idx == scd_pkg::QIDX_W'(scd_pkg::QUEUE_DEPTH - 1)) ?
                            '0 : r_wr_idx + 1'b1;
            end
            if (do_pop) begin
                r_rd_idx <= (r_rd_idx == scd_pkg::QIDX_W'(scd_pkg::QUEUE_DEPTH - 1)) ?
                            '0 : r_rd_idx + 1'b1;
            end
            if (i_push.valid && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push.valid && do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: design/scd_back.sv
`default_nettype none

module scd_back (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire scd_pkg::t_op_req            i_op,
    input  wire logic                        i_stall,
    output logic                             o_pop,
    output logic                             o_valid,
    output logic [scd_pkg::CHAR_W-1:0]       o_char_code,
    output logic                             o_char_valid
);

    logic [scd_pkg::CHAR_W-1:0] r_char_store [scd_pkg::FIFO_DEPTH];
    logic [scd_pkg::PTR_W-1:0]  r_wr_ptr;
    logic [scd_pkg::PTR_W-1:0]  r_rd_ptr;
    logic [scd_pkg::PTR_W-1:0]  wr_next;
    logic [scd_pkg::PTR_W-1:0]  rd_next;
    logic                       r_out_valid;
    logic [scd_pkg::CHAR_W-1:0] r_char_code;
    logic                       r_char_valid;
    logic                       out_free;
    logic                       do_push;
    logic                       do_read;
    logic                       fifo_empty;

    // Pointer arithmetic with wrap at the end of the store.
    assign wr_next = (r_wr_ptr == scd_pkg::PTR_W'(scd_pkg::FIFO_DEPTH - 1)) ?
                     '0 : r_wr_ptr + 1'b1;
    assign rd_next = (r_rd_ptr == scd_pkg::PTR_W'(scd_pkg::FIFO_DEPTH - 1)) ?
                     '0 : r_rd_ptr + 1'b1;
    assign fifo_empty = (r_wr_ptr == r_rd_ptr);

    // A push pops, lost if FIFO full; a read needs the output free.
    assign out_free = !r_out_valid || !i_stall;
    assign o_pop    = i_op.valid && (!i_op.op.is_read || out_free);
    assign do_push  = o_pop && !i_op.op.is_read && (wr_next != r_rd_ptr);
    assign do_read  = o_pop && i_op.op.is_read;

    // Character store, written at the write pointer.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_char_store[r_wr_ptr] <= i_op.op.ch;
        end
    end

    // Registered read of the oldest character into the output register.
    always_ff @(posedge i_clk) begin
        if (do_read) begin
            r_char_code <= fifo_empty ? '0 : r_char_store[r_rd_ptr];
        end
    end

    // Pointers, output valid and the character flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr     <= '0;
            r_rd_ptr     <= '0;
            r_out_valid  <= 1'b0;
            r_char_valid <= 1'b0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= wr_next;
            end
            if (do_read) begin
                r_out_valid  <= 1'b1;
                r_char_valid <= !fifo_empty;
                if (!fifo_empty) begin
                    r_rd_ptr <= rd_next;
                end
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_char_code  = r_char_code;
    assign o_char_valid = r_char_valid;

endmodule

`default_nettype wire

FILE: design/scancode_to_ascii_fifo.sv
// Channel  | Direction | Handshake         | Payload
// ---------+-----------+-------------------+----------------------------------
// input    | in        | i_valid / o_stall | i_command, i_scancode, i_aux_data
// output   | out       | o_valid / i_stall | o_char_code, o_char_valid
//
// One input transaction is taken per cycle while the two-entry operation
// queue has room; the back end retires one queued operation per cycle
// unless a read waits for a free output register. A read passes through
// the queue and then the registered read of the character store.
// Reset clears the pointers, the shift flag and the queue; the store keeps
// its contents. Output stall holds a read at the head of the queue and
// everything queued behind it; key presses ahead of that read still retire.
`default_nettype none

module scancode_to_ascii_fifo (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic                        i_command,
    input  wire logic [scd_pkg::CODE_W-1:0]  i_scancode,
    input  wire logic                        i_aux_data,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic [scd_pkg::CHAR_W-1:0]       o_char_code,
    output logic                             o_char_valid
);

    scd_pkg::t_op_req front_req;
    scd_pkg::t_op_req queue_head;
    logic             queue_full;
    logic             back_pop;

    // Front end: shift tracking and translation.
    scd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_command    (i_command),
        .i_scancode   (i_scancode),
        .i_aux_data   (i_aux_data),
        .i_queue_full (queue_full),
        .o_stall      (o_stall),
        .o_req        (front_req)
    );

    // Operation queue between the two halves.
    scd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_req),
        .i_pop   (back_pop),
        .o_full  (queue_full),
        .o_head  (queue_head)
    );

    // Back end: character FIFO and output register.
    scd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op         (queue_head),
        .i_stall      (i_stall),
        .o_pop        (back_pop),
        .o_valid      (o_valid),
        .o_char_code  (o_char_code),
        .o_char_valid (o_char_valid)
    );

    `include "assert_macros.svh"

    // The front end never pushes into a full queue.
    `ASSERT_NEVER(a_no_queue_overflow, i_clk, i_rst_n, front_req.valid && queue_full)
    // A returned character is never the null code.
    `ASSERT_CLK(a_char_nonzero, i_clk, i_rst_n, (o_valid && o_char_valid) |-> (o_char_code != '0))
    // An empty answer carries a zero code.
    `ASSERT_CLK(a_empty_zero, i_clk, i_rst_n, (o_valid && !o_char_valid) |-> (o_char_code == '0))

endmodule

`default_nettype wire
